FILE: sv/assert_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/btff_pkg.sv
// types and constants of the boundary tag first fit allocator
// no dependencies
package btff_pkg;

   localparam int HEAP_WORDS_DEFAULT = 16384;

   localparam logic [16:0] CHUNK_RESET = 17'd4096;

   localparam logic       KIND_ALLOC = 1'b0;
   localparam logic       KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OOM  = 2'd2;

   localparam logic [31:0] TAG_BYTES  = 32'd4;
   localparam logic [31:0] PAIR_BYTES = 32'd8;
   localparam logic [31:0] MIN_BLOCK  = 32'd16;
   localparam logic [31:0] ALLOC_BIT  = 32'd1;

   typedef struct packed {
      logic        kind;
      logic [15:0] request_bytes;
      logic [15:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_addr;
      logic [1:0]  status;
   } rsp_type;

endpackage

FILE: sv/boundary_tag_first_fit_allocator.sv
// boundary tag first fit heap allocator, top level
// depends on btff_pkg and assert_macros.svh
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | btff_pkg::req_type
//  rsp     | out       | rsp_valid / rsp_stall  | btff_pkg::rsp_type
//  csr     | in        | csr_wr_en              | csr_wr_data (chunk bytes)
//
// one item at a time; the tag memory has one write and one read port, with a registered read
// a zero request goes straight to the result; a free clears the flag in both tags and
// coalesces; an allocate walks the blocks first fit and carves the hit, split or not;
// when the walk fails the heap grows, is coalesced and carved, or out of memory ends it
// after reset a sweep over every heap word lays down prologue, epilogue and first chunk
// while req_stall stays high; csr writes are taken during the sweep
// a finished result waits in its own register, so a held rsp_stall only blocks the
// item after next
module boundary_tag_first_fit_allocator #(
   parameter int HEAP_WORDS = btff_pkg::HEAP_WORDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  btff_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output btff_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [16:0]       csr_wr_data
);
   import btff_pkg::*;

   `include "assert_macros.svh"

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int BW = $clog2(HEAP_WORDS * 4 + 1);
   localparam int SW = $clog2(HEAP_WORDS + 1);
   localparam logic [31:0] LIMIT = 32'(HEAP_WORDS * 4);
   // the first chunk fits only when the heap holds it past the prologue
   localparam bit INIT_FITS = (HEAP_WORDS * 4) >= 4112;
   localparam logic [BW-1:0] BRK_RESET = INIT_FITS ? BW'(4112) : BW'(16);

   typedef enum logic [5:0] {
      ST_INIT, ST_IDLE,
      ST_F0, ST_F1, ST_F2,
      ST_W0, ST_W1, ST_WCHK,
      ST_G0, ST_G1, ST_G2, ST_G3,
      ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
      ST_MPA1, ST_MPA2,
      ST_MNA1, ST_MNA2, ST_MNA3,
      ST_MN2, ST_MN3, ST_MN4, ST_MN5, ST_MN6, ST_MN7,
      ST_MRET,
      ST_C0, ST_C1, ST_CS2, ST_CS3, ST_CS4, ST_CN2,
      ST_FIN
   } state_type;

   // word address in range of the tag memory
   function automatic logic in_heap(input logic [31:0] a);
      return a[31:2] < 30'(HEAP_WORDS);
   endfunction

   // contents laid down by the sweep after reset
   function automatic logic [31:0] init_word(input logic [AW-1:0] idx);
      logic [31:0] v;
      v = 32'd0;
      if (idx == AW'(1) || idx == AW'(2)) begin
         v = PAIR_BYTES | ALLOC_BIT;
      end else if (idx == AW'(3)) begin
         v = INIT_FITS ? 32'd4096 : ALLOC_BIT;
      end else if (INIT_FITS && idx == AW'(1026)) begin
         v = 32'd4096;
      end else if (INIT_FITS && idx == AW'(1027)) begin
         v = ALLOC_BIT;
      end
      return v;
   endfunction

   // tag memory
   logic [31:0]   mem [HEAP_WORDS];
   logic [31:0]   rdata_ff;
   logic          rinr_ff;
   logic          mem_we;
   logic [AW-1:0] mem_widx;

   // control and working registers
   state_type     state_ff;
   req_type       req_ff;
   rsp_type       res_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic [16:0]   chunk_ff;
   logic [BW-1:0] brk_ff;
   logic [AW-1:0] init_idx_ff;
   logic [SW-1:0] steps_ff;
   logic          ret_carve_ff;
   logic          pa_ff;
   logic [31:0]   p_ff;
   logic [31:0]   b_ff;
   logic [31:0]   a_ff;
   logic [31:0]   sz_ff;
   logic [31:0]   s3_ff;
   logic [31:0]   hb_ff;
   logic [31:0]   fsz_ff;
   logic [31:0]   rest_ff;
   logic [31:0]   need_ff;

   // memory request of the current step
   logic [31:0]   rd_addr;
   logic          wr_en;
   logic [31:0]   wr_addr;
   logic [31:0]   wr_data;

   logic [31:0]   rv;
   logic [31:0]   rsz;
   logic [31:0]   brk_w;
   logic [31:0]   need_w;
   logic [31:0]   ext_w;
   logic [31:0]   gsz_w;
   logic          grow_ok;
   logic          split_w;
   logic [31:0]   sum_w;
   logic [31:0]   pfoot_w;
   logic          req_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // read data, zero past the end of the heap
   assign rv  = rinr_ff ? rdata_ff : 32'd0;
   assign rsz = {rv[31:3], 3'b000};

   assign brk_w  = {{(32 - BW){1'b0}}, brk_ff};
   // round the request up to an 8 byte block including both tags
   assign need_w = (req_ff.request_bytes <= 16'd8) ? MIN_BLOCK :
                   (({16'd0, req_ff.request_bytes} + 32'd15) & ~32'd7);
   assign ext_w  = (need_ff > {15'd0, chunk_ff}) ? need_ff : {15'd0, chunk_ff};
   // extension rounded up to an even number of words
   assign gsz_w  = (((ext_w >> 2) + 32'd1) >> 1) << 3;
   assign grow_ok = !(brk_w > LIMIT) && !(gsz_w > LIMIT - brk_w);
   assign split_w = (rsz >= need_ff) && ((rsz - need_ff) >= PAIR_BYTES);
   assign sum_w   = s3_ff + hb_ff + rsz;
   // footer of p re-read after its header was rewritten with sz
   assign pfoot_w = p_ff + (in_heap(p_ff - TAG_BYTES) ? sz_ff : 32'd0) - PAIR_BYTES;

   always_comb begin
      rd_addr = 32'd0;
      wr_en   = 1'b0;
      wr_addr = 32'd0;
      wr_data = 32'd0;
      case (state_ff)
         ST_F0:   rd_addr = p_ff - TAG_BYTES;
         ST_F1: begin
            wr_en = 1'b1; wr_addr = p_ff - TAG_BYTES; wr_data = rsz;
         end
         ST_F2: begin
            wr_en = 1'b1; wr_addr = p_ff + sz_ff - PAIR_BYTES; wr_data = sz_ff;
         end
         ST_W0:   rd_addr = TAG_BYTES;
         ST_W1:   rd_addr = PAIR_BYTES + rsz - TAG_BYTES;
         ST_WCHK: rd_addr = p_ff + rsz - TAG_BYTES;
         ST_G1: begin
            wr_en = 1'b1; wr_addr = p_ff - TAG_BYTES; wr_data = sz_ff;
         end
         ST_G2: begin
            wr_en = 1'b1; wr_addr = p_ff + sz_ff - PAIR_BYTES; wr_data = sz_ff;
         end
         ST_G3: begin
            wr_en = 1'b1; wr_addr = p_ff + sz_ff - TAG_BYTES; wr_data = ALLOC_BIT;
         end
         ST_M0:   rd_addr = p_ff - PAIR_BYTES;
         ST_M1:   rd_addr = p_ff - rsz - TAG_BYTES;
         ST_M2:   rd_addr = b_ff + rsz - PAIR_BYTES;
         ST_M3:   rd_addr = p_ff - TAG_BYTES;
         ST_M4:   rd_addr = p_ff + rsz - TAG_BYTES;
         ST_M5:   rd_addr = a_ff + rsz - PAIR_BYTES;
         ST_MPA1: begin
            wr_en = 1'b1; wr_addr = p_ff - TAG_BYTES; wr_data = sz_ff;
         end
         ST_MPA2: begin
            wr_en = 1'b1; wr_addr = pfoot_w; wr_data = sz_ff;
         end
         ST_MNA1: begin
            wr_en = 1'b1; wr_addr = p_ff + s3_ff - PAIR_BYTES; wr_data = sz_ff;
         end
         ST_MNA2: rd_addr = p_ff - PAIR_BYTES;
         ST_MNA3: begin
            wr_en = 1'b1; wr_addr = p_ff - rsz - TAG_BYTES; wr_data = sz_ff;
         end
         ST_MN2: begin
            wr_en = 1'b1; wr_addr = b_ff - TAG_BYTES; wr_data = sum_w;
         end
         ST_MN3:  rd_addr = p_ff - TAG_BYTES;
         ST_MN4:  rd_addr = p_ff + rsz - TAG_BYTES;
         ST_MN5: begin
            wr_en = 1'b1; wr_addr = a_ff + rsz - PAIR_BYTES; wr_data = sz_ff;
         end
         ST_MN6:  rd_addr = p_ff - PAIR_BYTES;
         ST_C0:   rd_addr = p_ff - TAG_BYTES;
         ST_C1: begin
            wr_en = 1'b1;
            if (split_w) begin
               wr_addr = p_ff + rsz - PAIR_BYTES; wr_data = rsz - need_ff;
            end else begin
               wr_addr = p_ff - TAG_BYTES; wr_data = rsz | ALLOC_BIT;
            end
         end
         ST_CS2: begin
            wr_en = 1'b1; wr_addr = p_ff - TAG_BYTES; wr_data = need_ff | ALLOC_BIT;
         end
         ST_CS3: begin
            wr_en = 1'b1; wr_addr = p_ff + need_ff - PAIR_BYTES;
            wr_data = need_ff | ALLOC_BIT;
         end
         ST_CS4: begin
            wr_en = 1'b1; wr_addr = p_ff + need_ff - TAG_BYTES; wr_data = rest_ff;
         end
         ST_CN2: begin
            wr_en = 1'b1; wr_addr = pfoot_w; wr_data = sz_ff | ALLOC_BIT;
         end
         default: ;
      endcase
   end

   // writes past the heap end are dropped; the sweep writes by index
   assign mem_we   = (state_ff == ST_INIT) || (wr_en && in_heap(wr_addr));
   assign mem_widx = (state_ff == ST_INIT) ? init_idx_ff : wr_addr[AW+1:2];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_widx] <= (state_ff == ST_INIT) ? init_word(init_idx_ff) : wr_data;
      end
      rdata_ff <= mem[rd_addr[AW+1:2]];
      rinr_ff  <= in_heap(rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_idx_ff  <= '0;
         chunk_ff     <= CHUNK_RESET;
         brk_ff       <= BRK_RESET;
         rsp_valid_ff <= 1'b0;
         ret_carve_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            chunk_ff <= csr_wr_data;
         end
         // output register drains independently of the sequencer
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               init_idx_ff <= init_idx_ff + AW'(1);
               if (init_idx_ff == AW'(HEAP_WORDS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_xfer) begin
                  req_ff <= req_data;
                  p_ff   <= {16'd0, req_data.block_addr};
                  if (req_data.kind == KIND_FREE) begin
                     state_ff <= ST_F0;
                  end else if (req_data.request_bytes == 16'd0) begin
                     res_ff   <= '{payload_addr: 16'd0, status: STATUS_ZERO};
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_W0;
                  end
               end
            end
            // free: clear the flag in both tags, then coalesce
            ST_F0: state_ff <= ST_F1;
            ST_F1: begin
               sz_ff        <= rsz;
               ret_carve_ff <= 1'b0;
               state_ff     <= ST_F2;
            end
            ST_F2: state_ff <= ST_M0;
            // first fit walk, one block per cycle
            ST_W0: begin
               need_ff  <= need_w;
               state_ff <= ST_W1;
            end
            ST_W1: begin
               p_ff     <= PAIR_BYTES + rsz;
               steps_ff <= '0;
               state_ff <= ST_WCHK;
            end
            ST_WCHK: begin
               if (steps_ff == SW'(HEAP_WORDS) || rsz == 32'd0) begin
                  state_ff <= ST_G0;
               end else if (!rv[0] && rsz >= need_ff) begin
                  state_ff <= ST_C0;
               end else begin
                  p_ff     <= p_ff + rsz;
                  steps_ff <= steps_ff + SW'(1);
               end
            end
            // extend the break and lay down new tags and epilogue
            ST_G0: begin
               if (!grow_ok) begin
                  res_ff   <= '{payload_addr: 16'd0, status: STATUS_OOM};
                  state_ff <= ST_FIN;
               end else begin
                  p_ff     <= brk_w;
                  brk_ff   <= BW'(brk_w + gsz_w);
                  sz_ff    <= gsz_w;
                  state_ff <= ST_G1;
               end
            end
            ST_G1: state_ff <= ST_G2;
            ST_G2: state_ff <= ST_G3;
            ST_G3: begin
               ret_carve_ff <= 1'b1;
               state_ff     <= ST_M0;
            end
            // coalesce: gather neighbor tags before any write
            ST_M0: state_ff <= ST_M1;
            ST_M1: begin
               b_ff     <= p_ff - rsz;
               state_ff <= ST_M2;
            end
            ST_M2: begin
               hb_ff    <= rsz;
               state_ff <= ST_M3;
            end
            ST_M3: begin
               pa_ff    <= rv[0];
               fsz_ff   <= rsz;
               state_ff <= ST_M4;
            end
            ST_M4: begin
               s3_ff    <= rsz;
               a_ff     <= p_ff + rsz;
               state_ff <= ST_M5;
            end
            ST_M5: begin
               if (pa_ff && rv[0]) begin
                  state_ff <= ST_MRET;
               end else if (pa_ff) begin
                  sz_ff    <= s3_ff + rsz;
                  state_ff <= ST_MPA1;
               end else if (rv[0]) begin
                  sz_ff    <= s3_ff + fsz_ff;
                  state_ff <= ST_MNA1;
               end else begin
                  state_ff <= ST_MN2;
               end
            end
            // next block free
            ST_MPA1: state_ff <= ST_MPA2;
            ST_MPA2: state_ff <= ST_MRET;
            // previous block free
            ST_MNA1: state_ff <= ST_MNA2;
            ST_MNA2: state_ff <= ST_MNA3;
            ST_MNA3: begin
               p_ff     <= p_ff - rsz;
               state_ff <= ST_MRET;
            end
            // both free; neighbors are re-read after each write
            ST_MN2: begin
               sz_ff    <= sum_w;
               state_ff <= ST_MN3;
            end
            ST_MN3: state_ff <= ST_MN4;
            ST_MN4: begin
               a_ff     <= p_ff + rsz;
               state_ff <= ST_MN5;
            end
            ST_MN5: state_ff <= ST_MN6;
            ST_MN6: state_ff <= ST_MN7;
            ST_MN7: begin
               p_ff     <= p_ff - rsz;
               state_ff <= ST_MRET;
            end
            ST_MRET: begin
               if (ret_carve_ff) begin
                  state_ff <= ST_C0;
               end else begin
                  res_ff   <= '{payload_addr: req_ff.block_addr, status: STATUS_OK};
                  state_ff <= ST_FIN;
               end
            end
            // carve: split when at least a tag pair remains
            ST_C0: state_ff <= ST_C1;
            ST_C1: begin
               sz_ff   <= rsz;
               rest_ff <= rsz - need_ff;
               if (split_w) begin
                  state_ff <= ST_CS2;
               end else begin
                  state_ff <= ST_CN2;
               end
            end
            ST_CS2: state_ff <= ST_CS3;
            ST_CS3: state_ff <= ST_CS4;
            ST_CS4, ST_CN2: begin
               res_ff   <= '{payload_addr: p_ff[15:0], status: STATUS_OK};
               state_ff <= ST_FIN;
            end
            // hand the result to the output register once it is free
            ST_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_brk_in_heap, clock, reset, brk_w <= LIMIT, "break pointer past heap end")
   `ASSERT_IMPL(a_walk_bound, clock, reset, state_ff == ST_WCHK, steps_ff <= SW'(HEAP_WORDS), "walk overran")
   `ASSERT_IMPL(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FIN), "result loaded outside finish")
   `ASSERT_NEXT(a_fin_loads, clock, reset, state_ff == ST_FIN && !rsp_valid_ff, rsp_valid_ff && state_ff == ST_IDLE, "free output register not loaded")

endmodule

FILE: dv/tb.sv
// testbench for the boundary tag first fit allocator: directed and random allocate/free traffic
// checked against an in-bench heap predictor held in a small scoreboard class
// depends on btff_pkg and the boundary_tag_first_fit_allocator rtl
`timescale 1ns / 1ps

module tb;
   import btff_pkg::*;

   localparam int          HEAP_WORDS = 16384;
   localparam int unsigned CYCLE_LIMIT = 20_000_000;
   localparam int          RANDOM_ITEMS = 650;
   localparam int          QUIET_FIRST = 250;
   localparam int          QUIET_LAST = 380;

   // heap predictor plus the queue of results still owed by the block
   class heap_scoreboard;
      int unsigned words[HEAP_WORDS];
      int unsigned brk;
      int unsigned first_blk;
      int unsigned chunk;
      rsp_type     owed[$];
      int          errors;

      function new();
         int unsigned dummy;
         foreach (words[i]) words[i] = 0;
         errors = 0;
         chunk = 32'(CHUNK_RESET);
         words[1] = PAIR_BYTES | ALLOC_BIT;
         words[2] = PAIR_BYTES | ALLOC_BIT;
         words[3] = ALLOC_BIT;
         brk = 16;
         first_blk = 8;
         void'(extend(32'(CHUNK_RESET), dummy));
      endfunction

      function int unsigned heap_rd(int unsigned a);
         int unsigned i;
         i = a >> 2;
         return (i < HEAP_WORDS) ? words[i] : 0;
      endfunction

      function void heap_wr(int unsigned a, int unsigned v);
         int unsigned i;
         i = a >> 2;
         if (i < HEAP_WORDS) words[i] = v;
      endfunction

      function int unsigned tag_size(int unsigned a);
         return heap_rd(a) & ~32'h7;
      endfunction

      function int unsigned tag_used(int unsigned a);
         return heap_rd(a) & ALLOC_BIT;
      endfunction

      function int unsigned hdr(int unsigned p);
         return p - TAG_BYTES;
      endfunction

      function int unsigned ftr(int unsigned p);
         return p + tag_size(p - TAG_BYTES) - PAIR_BYTES;
      endfunction

      function int unsigned next_blk(int unsigned p);
         return p + tag_size(p - TAG_BYTES);
      endfunction

      function int unsigned prev_blk(int unsigned p);
         return p - tag_size(p - PAIR_BYTES);
      endfunction

      function int unsigned coalesce(int unsigned p);
         int unsigned pa, na, sz;
         pa = tag_used(ftr(prev_blk(p)));
         na = tag_used(hdr(next_blk(p)));
         sz = tag_size(hdr(p));
         if (pa != 0 && na != 0) return p;
         if (pa != 0) begin
            sz += tag_size(hdr(next_blk(p)));
            heap_wr(hdr(p), sz);
            heap_wr(ftr(p), sz);
         end else if (na != 0) begin
            sz += tag_size(ftr(prev_blk(p)));
            heap_wr(ftr(p), sz);
            heap_wr(hdr(prev_blk(p)), sz);
            p = prev_blk(p);
         end else begin
            sz += tag_size(hdr(prev_blk(p))) + tag_size(ftr(next_blk(p)));
            heap_wr(hdr(prev_blk(p)), sz);
            heap_wr(ftr(next_blk(p)), sz);
            p = prev_blk(p);
         end
         return p;
      endfunction

      // grows the break by an even number of words; 0 when the heap end would be passed
      function bit extend(int unsigned bytes, output int unsigned blk);
         int unsigned nw, sz, lim, p;
         nw = bytes / TAG_BYTES;
         sz = ((nw & 1) != 0 ? nw + 1 : nw) * TAG_BYTES;
         lim = HEAP_WORDS * TAG_BYTES;
         blk = 0;
         if (brk > lim || sz > lim - brk) return 0;
         p = brk;
         brk += sz;
         heap_wr(hdr(p), sz);
         heap_wr(ftr(p), sz);
         heap_wr(hdr(next_blk(p)), ALLOC_BIT);
         blk = coalesce(p);
         return 1;
      endfunction

      // first free block of at least need bytes; the walk gives up on corrupt tags
      function bit scan_first_fit(int unsigned need, output int unsigned blk);
         int unsigned p, sz;
         p = next_blk(first_blk);
         blk = 0;
         for (int unsigned n = 0; n < HEAP_WORDS; n++) begin
            sz = tag_size(hdr(p));
            if (sz == 0) return 0;
            if (tag_used(hdr(p)) == 0 && sz >= need) begin
               blk = p;
               return 1;
            end
            p += sz;
         end
         return 0;
      endfunction

      function void place(int unsigned p, int unsigned need);
         int unsigned sz, rest;
         sz = tag_size(hdr(p));
         if (sz >= need && sz - need >= PAIR_BYTES) begin
            rest = sz - need;
            heap_wr(ftr(p), rest);
            heap_wr(hdr(p), need | ALLOC_BIT);
            heap_wr(ftr(p), need | ALLOC_BIT);
            heap_wr(hdr(next_blk(p)), rest);
         end else begin
            heap_wr(hdr(p), sz | ALLOC_BIT);
            heap_wr(ftr(p), sz | ALLOC_BIT);
         end
      endfunction

      function void set_chunk(logic [16:0] v);
         chunk = 32'(v);
      endfunction

      // accepted request: update the heap image and queue the owed result
      function rsp_type note_request(req_type r);
         rsp_type     e;
         int unsigned a, req, need, blk, sz, ext;
         a = 32'(r.block_addr);
         req = 32'(r.request_bytes);
         e.payload_addr = '0;
         e.status = STATUS_OK;
         if (r.kind == KIND_FREE) begin
            sz = tag_size(hdr(a));
            heap_wr(hdr(a), sz);
            heap_wr(ftr(a), sz);
            void'(coalesce(a));
            e.payload_addr = r.block_addr;
         end else if (req == 0) begin
            e.status = STATUS_ZERO;
         end else begin
            need = (req <= PAIR_BYTES) ? MIN_BLOCK
                   : PAIR_BYTES * ((req + PAIR_BYTES + PAIR_BYTES - 1) / PAIR_BYTES);
            if (scan_first_fit(need, blk)) begin
               place(blk, need);
               e.payload_addr = blk[15:0];
            end else begin
               ext = (need > chunk) ? need : chunk;
               if (extend(ext, blk)) begin
                  place(blk, need);
                  e.payload_addr = blk[15:0];
               end else begin
                  e.status = STATUS_OOM;
               end
            end
         end
         owed.push_back(e);
         return e;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (owed.size() == 0) begin
            $error("unexpected result payload_addr %0h status %0d", got.payload_addr, got.status);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.payload_addr !== e.payload_addr) begin
            $error("payload_addr expected %0h actual %0h", e.payload_addr, got.payload_addr);
            errors++;
         end
         if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;

   heap_scoreboard sb;
   int unsigned    cycles;
   bit             quiet;
   int unsigned    live_blocks[$];

   boundary_tag_first_fit_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // every accepted result transfer is checked
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // result side backpressure, quiet during the no idle stretch
   always @(negedge clock) begin
      if (reset || quiet) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 19);
   end

   // one request transfer, with an optional random gap first
   task automatic send(logic kind, logic [15:0] bytes, logic [15:0] addr);
      req_type r;
      rsp_type e;
      r.kind = kind;
      r.request_bytes = bytes;
      r.block_addr = addr;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 19) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      e = sb.note_request(r);
      if (kind == KIND_ALLOC && e.status == STATUS_OK) begin
         live_blocks.push_back(32'(e.payload_addr));
      end
   endtask

   task automatic alloc(logic [15:0] bytes);
      send(KIND_ALLOC, bytes, 16'($urandom()));
   endtask

   // frees a random live block, or the newest one
   task automatic free_live(bit newest);
      int idx;
      int unsigned a;
      if (live_blocks.size() == 0) return;
      idx = newest ? live_blocks.size() - 1 : $urandom_range(live_blocks.size() - 1);
      a = live_blocks[idx];
      live_blocks.delete(idx);
      send(KIND_FREE, 16'($urandom()), a[15:0]);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   // chunk register written only once the block has gone idle
   task automatic write_chunk(logic [16:0] v);
      drain();
      repeat (40) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      sb.set_chunk(v);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [15:0] random_size();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return 16'($urandom_range(64, 1));
      if (pick < 90) return 16'($urandom_range(1024, 65));
      if (pick < 98) return 16'($urandom_range(8192, 1025));
      if (pick < 99) return 16'd0;
      return 16'($urandom());
   endfunction

   initial begin
      logic [16:0] chunk_plan[5];
      sb = new();
      cycles = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero request, minimum sizes, split and no split, growth, merges, oom
      alloc(16'd0);
      alloc(16'd1);
      alloc(16'd8);
      alloc(16'd9);
      alloc(16'd16);
      alloc(16'd3000);
      alloc(16'd1000);
      alloc(16'd5000);
      free_live(1'b0);
      free_live(1'b0);
      free_live(1'b1);
      alloc(16'd65535);
      alloc(16'd24);
      free_live(1'b0);
      free_live(1'b0);
      alloc(16'd40000);
      alloc(16'd30000);
      while (live_blocks.size() != 0) free_live(1'b0);
      drain();

      chunk_plan[0] = 17'd16;
      chunk_plan[1] = 17'd65536;
      chunk_plan[2] = 17'd100;
      chunk_plan[3] = 17'd65535;
      chunk_plan[4] = CHUNK_RESET;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 130 == 0) write_chunk(chunk_plan[n / 130]);
         // sender holds off once until every owed result is back
         if (n == 500) drain();
         quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
         if (live_blocks.size() != 0 && $urandom_range(99) < 40) free_live(1'b0);
         else alloc(random_size());
      end
      quiet = 1'b0;

      // frees of arbitrary addresses come last since they may corrupt the tags
      send(KIND_FREE, 16'hFFFF, 16'hFFFF);
      send(KIND_FREE, 16'h0000, 16'h0000);
      repeat (4) send(KIND_FREE, 16'($urandom()), 16'($urandom()));
      alloc(16'd32);

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
